### sv/size_class_free_list_allocator_assert.svh
// Assertion macros shared by the allocator modules.
// They expect clk_i and rst_ni in the scope of the module that uses them.
`ifndef SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SIZE_CLASS_FREE_LIST_ALLOCATOR_ASSERT_SVH

// The property must hold at every clock edge outside reset.
`define SFLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// The condition must never be true at a clock edge outside reset.
`define SFLA_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

### sv/sfla_pkg.sv
package sfla_pkg;

  // Sizing of the allocator.
  localparam int unsigned MAX_BLOCK_BYTES = 16384;
  localparam int unsigned GRAIN_BYTES     = 8;
  localparam int unsigned NODES_PER_CHUNK = 64;
  localparam int unsigned POOL_BYTES      = 1048576;

  // Field widths of the request and response words.
  localparam int unsigned SIZE_W = 15;
  localparam int unsigned ADDR_W = 20;

  // Derived sizes.
  localparam int unsigned NUM_CLASSES = (MAX_BLOCK_BYTES + GRAIN_BYTES - 1) / GRAIN_BYTES;
  localparam int unsigned CLS_W       = $clog2(NUM_CLASSES);
  localparam int unsigned NODE_W      = $clog2(NUM_CLASSES * GRAIN_BYTES + 1);
  localparam int unsigned CNT_W       = $clog2(NODES_PER_CHUNK + 1);
  localparam int unsigned POOL_W      = $clog2(POOL_BYTES + 1);
  localparam int unsigned LINK_DEPTH  = POOL_BYTES / GRAIN_BYTES;
  localparam int unsigned LINK_W      = $clog2(LINK_DEPTH);

  // Command codes.
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Response status codes.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_SIZE      = 2'd1;
  localparam logic [1:0] STAT_EXHAUSTED = 2'd2;

  typedef struct packed {
    logic              command;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] block_address;
  } sfla_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic [1:0]        status;
  } sfla_rsp_t;

  // Top of a free stack; empty marks a stack with no entry.
  typedef struct packed {
    logic              empty;
    logic [ADDR_W-1:0] addr;
  } head_t;

  // One entry of the class table.
  typedef struct packed {
    head_t             head;
    logic [ADDR_W-1:0] carve_next;
    logic [CNT_W-1:0]  carve_left;
  } cls_word_t;

  // Chunk geometry for one class.
  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [NODE_W-1:0] chunk;
  } div_res_t;

  localparam cls_word_t CLS_WORD_RESET = '{
    head: '{empty: 1'b1, addr: '0},
    carve_next: '0,
    carve_left: '0
  };

endpackage

### sv/sfla_ram.sv
module sfla_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one read port with registered read data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/sfla_chunk_div.sv
`include "size_class_free_list_allocator_assert.svh"

module sfla_chunk_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [sfla_pkg::NODE_W-1:0]  node_i,
  output logic                         done_o,
  output sfla_pkg::div_res_t           res_o
);
  import sfla_pkg::*;

  localparam int unsigned TRIAL_W = NODE_W + CNT_W;
  localparam int unsigned BIT_W   = $clog2(CNT_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [BIT_W-1:0]   bit_q, bit_d;
  logic [CNT_W-1:0]   q_q, q_d;
  logic [NODE_W-1:0]  prod_q, prod_d;
  logic [NODE_W-1:0]  node_q, node_d;
  logic [TRIAL_W-1:0] cap_prod;
  logic [TRIAL_W-1:0] trial;

  // A full chunk of the node limit, checked against the chunk byte limit.
  assign cap_prod = TRIAL_W'(node_i) * TRIAL_W'(NODES_PER_CHUNK);

  // Next partial product when the current quotient bit is set.
  assign trial = TRIAL_W'(prod_q) + (TRIAL_W'(node_q) << bit_q);

  // Restoring division, one quotient bit per cycle, most significant first.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    bit_d  = bit_q;
    q_d    = q_q;
    prod_d = prod_q;
    node_d = node_q;
    if (start_i) begin
      node_d = node_i;
      if (cap_prod <= TRIAL_W'(MAX_BLOCK_BYTES)) begin
        q_d    = CNT_W'(NODES_PER_CHUNK);
        prod_d = NODE_W'(cap_prod);
        done_d = 1'b1;
      end else if (32'(node_i) > MAX_BLOCK_BYTES) begin
        // A node above the byte limit makes a chunk of one node.
        q_d    = CNT_W'(1);
        prod_d = node_i;
        done_d = 1'b1;
      end else begin
        q_d    = '0;
        prod_d = '0;
        bit_d  = BIT_W'(CNT_W - 1);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (trial <= TRIAL_W'(MAX_BLOCK_BYTES)) begin
        q_d    = q_q | (CNT_W'(1) << bit_q);
        prod_d = NODE_W'(trial);
      end
      if (bit_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        bit_d = bit_q - BIT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q  <= bit_d;
    q_q    <= q_d;
    prod_q <= prod_d;
    node_q <= node_d;
  end

  assign done_o      = done_q;
  assign res_o.count = q_q;
  assign res_o.chunk = prod_q;

  `SFLA_ASSERT_NEVER(a_start_while_busy, start_i && busy_q,
                     "Divider started while a division is running")
  `SFLA_ASSERT(a_done_count_range,
               done_o |-> (q_q != '0) && (32'(q_q) <= NODES_PER_CHUNK),
               "Chunk node count out of range")
  `SFLA_ASSERT(a_done_after_last_bit, busy_q && (bit_q == '0) |=> done_q && !busy_q,
               "Division did not finish after its last quotient bit")

endmodule

### sv/size_class_free_list_allocator.sv
// Size-class free-list allocator. Each request word allocates a block of the
// given byte size or frees a block at the given address; each gives exactly one
// response word with the granted address and a status. Class state (free stack
// head, next uncarved node, nodes left in the chunk) sits in a 2048-entry table
// RAM and the stack links in a 131072-entry link RAM, both with registered
// reads. After reset the block clears the class table, one entry per cycle,
// with in_ready_o low. A request with a size error goes straight to the
// response; a free or a carve from the current chunk reads the class entry and
// writes it back; a pop from a free stack adds a second dependent read, of the
// link RAM; and a new chunk taken from the pool waits for the bit-serial chunk
// node count divider. The next request is accepted only after the current one
// is done. The response register lets the next request be accepted while a
// response still waits.
`include "size_class_free_list_allocator_assert.svh"

module size_class_free_list_allocator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  sfla_pkg::sfla_req_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sfla_pkg::sfla_rsp_t  out_data_o
);
  import sfla_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LOOK  = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]        state_q, state_d;
  logic [CLS_W-1:0]  clr_q, clr_d;
  logic [POOL_W-1:0] pool_q, pool_d;
  logic              out_valid_q, out_valid_d;
  sfla_rsp_t         out_q, out_d;
  sfla_rsp_t         res_q, res_d;

  // Request held for the duration of its processing.
  logic              cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [CLS_W-1:0]  cls_q;
  logic [NODE_W-1:0] node_q;
  logic              load_req;

  // Decode of the incoming word.
  logic              in_bad;
  logic [SIZE_W-1:0] size_m1;
  logic [SIZE_W-1:0] cls_full;
  logic [CLS_W-1:0]  in_cls;
  logic [NODE_W-1:0] in_node;

  // Memory ports.
  logic              cls_we, cls_re;
  logic [CLS_W-1:0]  cls_waddr;
  cls_word_t         cls_wdata, cw_rd;
  logic              link_we, link_re;
  logic [LINK_W-1:0] link_waddr, link_raddr;
  head_t             link_wdata, link_rd;

  // Chunk geometry unit.
  logic              div_start, div_done;
  div_res_t          div_res;
  logic [POOL_W:0]   pool_sum;

  assign size_m1  = in_data_i.size_bytes - SIZE_W'(1);
  assign cls_full = SIZE_W'(size_m1 / GRAIN_BYTES);
  assign in_bad   = (in_data_i.size_bytes == '0) ||
                    (32'(in_data_i.size_bytes) > MAX_BLOCK_BYTES);
  assign in_cls   = (32'(cls_full) >= NUM_CLASSES) ? CLS_W'(NUM_CLASSES - 1)
                                                   : CLS_W'(cls_full);
  assign in_node  = NODE_W'((32'(in_cls) + 32'd1) * GRAIN_BYTES);

  assign pool_sum = (POOL_W + 1)'(pool_q) + (POOL_W + 1)'(div_res.chunk);

  sfla_ram #(
    .WIDTH ($bits(cls_word_t)),
    .DEPTH (NUM_CLASSES)
  ) u_cls_ram (
    .clk_i   (clk_i),
    .we_i    (cls_we),
    .waddr_i (cls_waddr),
    .wdata_i (cls_wdata),
    .re_i    (cls_re),
    .raddr_i (in_cls),
    .rdata_o (cw_rd)
  );

  sfla_ram #(
    .WIDTH ($bits(head_t)),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .re_i    (link_re),
    .raddr_i (link_raddr),
    .rdata_o (link_rd)
  );

  sfla_chunk_div u_chunk_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .node_i  (node_q),
    .done_o  (div_done),
    .res_o   (div_res)
  );

  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer: read the class entry, modify it and write it back.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pool_d     = pool_q;
    res_d      = res_q;
    load_req   = 1'b0;
    cls_we     = 1'b0;
    cls_re     = 1'b0;
    cls_waddr  = cls_q;
    cls_wdata  = cw_rd;
    link_we    = 1'b0;
    link_re    = 1'b0;
    link_waddr = LINK_W'(addr_q / GRAIN_BYTES);
    link_wdata = cw_rd.head;
    link_raddr = LINK_W'(cw_rd.head.addr / GRAIN_BYTES);
    div_start  = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cls_we    = 1'b1;
        cls_waddr = clr_q;
        cls_wdata = CLS_WORD_RESET;
        clr_d     = clr_q + CLS_W'(1);
        if (32'(clr_q) == NUM_CLASSES - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          load_req = 1'b1;
          if (in_bad) begin
            res_d   = '{granted_address: '0, status: STAT_SIZE};
            state_d = S_OUT;
          end else begin
            cls_re  = 1'b1;
            state_d = S_LOOK;
          end
        end
      end
      S_LOOK: begin
        if (cmd_q == CMD_FREE) begin
          // Push: the old head goes into the link of the freed block.
          link_we              = 1'b1;
          cls_we               = 1'b1;
          cls_wdata.head.empty = 1'b0;
          cls_wdata.head.addr  = addr_q;
          res_d                = '{granted_address: '0, status: STAT_OK};
          state_d              = S_OUT;
        end else if (!cw_rd.head.empty) begin
          // Pop: fetch the link of the head block first.
          link_re = 1'b1;
          state_d = S_LINK;
        end else if (cw_rd.carve_left != '0) begin
          cls_we               = 1'b1;
          cls_wdata.carve_next = cw_rd.carve_next + ADDR_W'(node_q);
          cls_wdata.carve_left = cw_rd.carve_left - CNT_W'(1);
          res_d = '{granted_address: cw_rd.carve_next, status: STAT_OK};
          state_d = S_OUT;
        end else begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end
      end
      S_LINK: begin
        cls_we         = 1'b1;
        cls_wdata.head = link_rd;
        res_d   = '{granted_address: cw_rd.head.addr, status: STAT_OK};
        state_d = S_OUT;
      end
      S_DIV: begin
        if (div_done) begin
          if (pool_sum > (POOL_W + 1)'(POOL_BYTES)) begin
            res_d = '{granted_address: '0, status: STAT_EXHAUSTED};
          end else begin
            // New chunk: hand out its first node, keep the rest for carving.
            cls_we               = 1'b1;
            cls_wdata.carve_next = ADDR_W'(pool_q) + ADDR_W'(node_q);
            cls_wdata.carve_left = div_res.count - CNT_W'(1);
            pool_d               = POOL_W'(pool_sum);
            res_d = '{granted_address: ADDR_W'(pool_q), status: STAT_OK};
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Response register: loaded when the slot is free or being emptied.
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_OUT) && (!out_valid_q || out_ready_i)) begin
      out_d       = res_q;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pool_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      pool_q      <= pool_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    res_q <= res_d;
    if (load_req) begin
      cmd_q  <= in_data_i.command;
      addr_q <= in_data_i.block_address;
      cls_q  <= in_cls;
      node_q <= in_node;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SFLA_ASSERT_NEVER(a_cls_rw_overlap, cls_we && cls_re,
                     "Class table read and written in the same cycle")
  `SFLA_ASSERT(a_link_write_on_free,
               link_we |-> (state_q == S_LOOK) && (cmd_q == CMD_FREE),
               "Link memory written outside a free")
  `SFLA_ASSERT(a_bad_size_reply,
               in_valid_i && in_ready_o && in_bad |=>
                 (state_q == S_OUT) && (res_q.status == STAT_SIZE),
               "Bad size request did not produce a size error")
  `SFLA_ASSERT(a_pool_bound, pool_q <= POOL_W'(POOL_BYTES),
               "Pool top beyond the pool end")
  `SFLA_ASSERT(a_error_zero_addr,
               out_valid_o && (out_data_o.status != STAT_OK) |->
                 (out_data_o.granted_address == '0),
               "Error response carries a nonzero address")

endmodule

### dv/sfla_grant_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the allocator, keeps its own copy of the class
// table, the pool top and the link store, and checks every response word.
module sfla_grant_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  sfla_pkg::sfla_req_t in_data_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  sfla_pkg::sfla_rsp_t out_data_i,
  output int                  mismatches_o,
  output int                  grants_owed_o
);
  import sfla_pkg::*;

  // Shadow allocator state.
  head_t             free_top  [NUM_CLASSES];
  logic [ADDR_W-1:0] carve_at  [NUM_CLASSES];
  logic [CNT_W-1:0]  carve_rest[NUM_CLASSES];
  logic [POOL_W-1:0] pool_mark;
  head_t             link_mem  [LINK_DEPTH];

  sfla_rsp_t grants_due[$];
  sfla_rsp_t owed;
  int        mismatch_count;

  // Works out the response word of one request and updates the shadow state.
  function automatic sfla_rsp_t predict_grant(sfla_req_t req);
    sfla_rsp_t         rsp;
    logic [CLS_W-1:0]  cls;
    int unsigned       node;
    int unsigned       count;
    int unsigned       chunk;
    head_t             top;
    rsp = '{granted_address: '0, status: STAT_OK};
    if (req.size_bytes == 0 || req.size_bytes > MAX_BLOCK_BYTES) begin
      rsp.status = STAT_SIZE;
      return rsp;
    end
    cls  = CLS_W'((req.size_bytes - 1) / GRAIN_BYTES);
    node = (32'(cls) + 1) * GRAIN_BYTES;

    // A free is pushed as given, whatever the address.
    if (req.command == CMD_FREE) begin
      link_mem[LINK_W'(req.block_address / GRAIN_BYTES)] = free_top[cls];
      free_top[cls] = '{empty: 1'b0, addr: req.block_address};
      return rsp;
    end

    // Pop the freed stack first.
    top = free_top[cls];
    if (!top.empty) begin
      free_top[cls] = link_mem[LINK_W'(top.addr / GRAIN_BYTES)];
      rsp.granted_address = top.addr;
      return rsp;
    end

    // Then carve from the current chunk.
    if (carve_rest[cls] != 0) begin
      rsp.granted_address = carve_at[cls];
      carve_at[cls]   = carve_at[cls] + ADDR_W'(node);
      carve_rest[cls] = carve_rest[cls] - 1'b1;
      return rsp;
    end

    // Otherwise take a new chunk from the pool top.
    count = MAX_BLOCK_BYTES / node;
    if (count > NODES_PER_CHUNK) count = NODES_PER_CHUNK;
    if (count == 0) count = 1;
    chunk = count * node;
    if (chunk > POOL_BYTES || pool_mark > POOL_BYTES - chunk) begin
      rsp.status = STAT_EXHAUSTED;
      return rsp;
    end
    carve_at[cls]       = ADDR_W'(pool_mark + node);
    carve_rest[cls]     = CNT_W'(count - 1);
    rsp.granted_address = ADDR_W'(pool_mark);
    pool_mark           = pool_mark + POOL_W'(chunk);
    return rsp;
  endfunction

  // Compare responses first, since a word accepted at this edge cannot answer
  // a request accepted at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        free_top[c]   = '{empty: 1'b1, addr: '0};
        carve_at[c]   = '0;
        carve_rest[c] = '0;
      end
      pool_mark = '0;
      grants_due.delete();
      mismatch_count = 0;
      mismatches_o  <= 0;
      grants_owed_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (grants_due.size() == 0) begin
          $display("%0t: unexpected response, expected none, got address %h status %0d",
                   $time, out_data_i.granted_address, out_data_i.status);
          mismatch_count++;
        end else begin
          owed = grants_due.pop_front();
          if (out_data_i.granted_address !== owed.granted_address) begin
            $display("%0t: granted_address mismatch, expected %h, got %h",
                     $time, owed.granted_address, out_data_i.granted_address);
            mismatch_count++;
          end
          if (out_data_i.status !== owed.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, owed.status, out_data_i.status);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        grants_due.push_back(predict_grant(in_data_i));
      end
      mismatches_o  <= mismatch_count;
      grants_owed_o <= grants_due.size();
    end
  end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import sfla_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      req_valid;
  logic      req_ready;
  sfla_req_t req_word;
  logic      rsp_valid;
  logic      rsp_ready;
  sfla_rsp_t rsp_word;
  int        mismatches;
  int        grants_owed;

  // Node sizes that most random requests use, so stacks and chunks get reused.
  int unsigned hot_nodes[6];
  int          sent_words;
  int unsigned send_gap_max;

  always #5 clk = ~clk;

  size_class_free_list_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (req_ready),
    .in_data_i   (req_word),
    .out_valid_o (rsp_valid),
    .out_ready_i (rsp_ready),
    .out_data_o  (rsp_word)
  );

  sfla_grant_checker grant_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (req_valid),
    .in_ready_i    (req_ready),
    .in_data_i     (req_word),
    .out_valid_i   (rsp_valid),
    .out_ready_i   (rsp_ready),
    .out_data_i    (rsp_word),
    .mismatches_o  (mismatches),
    .grants_owed_o (grants_owed)
  );

  // Offers one request word after a random gap and holds it until accepted.
  // Valid stays high across back-to-back words.
  task automatic send_word(sfla_req_t req);
    int unsigned gap;
    if (sent_words % 50 == 0) send_gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
    sent_words++;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req_word  <= req;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic send_fields(logic cmd, int unsigned size, int unsigned addr);
    send_word('{command: cmd, size_bytes: SIZE_W'(size), block_address: ADDR_W'(addr)});
  endtask

  // Stops offering and waits until every response has come back.
  task automatic wait_all_granted();
    req_valid <= 1'b0;
    @(posedge clk);
    while (grants_owed != 0) @(posedge clk);
  endtask

  // Mostly hot sizes with random addresses; some random, edge and bad sizes.
  function automatic sfla_req_t random_request();
    sfla_req_t   req;
    int unsigned pick;
    req.command       = ($urandom_range(0, 99) < 55) ? CMD_ALLOC : CMD_FREE;
    req.block_address = ADDR_W'($urandom());
    if ($urandom_range(0, 99) < 85) req.block_address[2:0] = '0;
    pick = $urandom_range(0, 99);
    if (pick < 82) begin
      req.size_bytes = SIZE_W'(hot_nodes[$urandom_range(0, 5)] - $urandom_range(0, 7));
    end else if (pick < 94) begin
      req.size_bytes = SIZE_W'($urandom_range(1, MAX_BLOCK_BYTES));
    end else if (pick < 97) begin
      req.size_bytes = ($urandom_range(0, 1) == 0) ? '0 : SIZE_W'(MAX_BLOCK_BYTES);
    end else begin
      req.size_bytes = SIZE_W'($urandom_range(MAX_BLOCK_BYTES + 1, 32767));
    end
    return req;
  endfunction

  // Response side: random stalls per word, and one long hold-off that lets the
  // block fill up and push back on the request side.
  initial begin
    int          taken;
    int unsigned gap;
    int unsigned gap_max;
    taken     = 0;
    gap_max   = 0;
    rsp_ready = 1'b0;
    forever begin
      if (taken % 50 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : 12;
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
        rsp_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      taken++;
      if (taken == 500) begin
        rsp_ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
    end
  end

  // Stimulus and verdict.
  initial begin
    rst_n        = 1'b0;
    req_valid    = 1'b0;
    req_word     = '0;
    sent_words   = 0;
    send_gap_max = 0;
    for (int i = 0; i < 4; i++) hot_nodes[i] = GRAIN_BYTES * $urandom_range(1, 32);
    for (int i = 4; i < 6; i++) hot_nodes[i] = GRAIN_BYTES * $urandom_range(33, 2048);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Bad sizes, for allocate and free alike.
    send_fields(CMD_ALLOC, 0, 0);
    send_fields(CMD_FREE, 0, 20'hFFFFF);
    send_fields(CMD_ALLOC, MAX_BLOCK_BYTES + 1, 0);
    send_fields(CMD_ALLOC, 32767, 20'hFFFFF);
    // New chunk, then a carve, in the smallest classes.
    send_fields(CMD_ALLOC, 1, 0);
    send_fields(CMD_ALLOC, 8, 0);
    send_fields(CMD_ALLOC, 9, 0);
    // Largest blocks: one node per chunk.
    send_fields(CMD_ALLOC, MAX_BLOCK_BYTES, 0);
    send_fields(CMD_ALLOC, MAX_BLOCK_BYTES, 0);
    send_fields(CMD_FREE, MAX_BLOCK_BYTES, 20'hFFFFF);
    send_fields(CMD_ALLOC, MAX_BLOCK_BYTES, 0);
    // Unaligned and aliasing frees share one link entry.
    send_fields(CMD_FREE, 5, 20'h00000);
    send_fields(CMD_FREE, 3, 20'h00123);
    send_fields(CMD_FREE, 8, 20'h00120);
    send_fields(CMD_ALLOC, 2, 0);
    send_fields(CMD_ALLOC, 7, 0);
    send_fields(CMD_ALLOC, 4, 0);
    // Double free of one block.
    send_fields(CMD_FREE, 16, 20'h00040);
    send_fields(CMD_FREE, 16, 20'h00040);
    send_fields(CMD_ALLOC, 10, 0);
    send_fields(CMD_ALLOC, 12, 0);
    send_fields(CMD_ALLOC, 16, 0);
    // The address of an allocate is ignored.
    send_fields(CMD_ALLOC, 2048, 20'hABCDE);
    wait_all_granted();

    // Random traffic.
    repeat (1560) send_word(random_request());
    wait_all_granted();

    // Drain the pool with largest blocks until it runs out.
    repeat (70) send_fields(CMD_ALLOC, MAX_BLOCK_BYTES, $urandom());
    wait_all_granted();
    repeat (20) @(posedge clk);

    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
